FILE: hw/rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants of the FIFO page replacement block.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int FRAMES_DEFAULT    = 5;
  localparam int PAGE_BITS_DEFAULT = 16;

  // stream payload widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_IN_USE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_PERIOD  = 1'b1;

  localparam logic [2:0]  FRAMES_IN_USE_RESET = 3'd5;
  localparam logic [15:0] CLEAR_PERIOD_RESET  = 16'd19;

  // command codes
  localparam logic [1:0] CMD_IDLE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_MISS,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/fpr_ram.sv
// ----------------------------------------------------------------------------
// fpr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module fpr_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 5,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/fifo_page_replacement.sv
// ----------------------------------------------------------------------------
// fifo_page_replacement
// FIFO page replacement with referenced and modified bits, one tick per item.
// ----------------------------------------------------------------------------
// Each input item is one tick (idle, read or write access). The resident
// pages sit in a small RAM that a single comparator searches from the oldest
// frame onwards, a RAM read and then a compare per frame. An idle tick goes
// straight to its result, a hit ends the search at the matching frame, and a
// miss searches every occupied frame and then writes the page in a miss step;
// the RAM read port and the one comparator set this pace. s_tready is high
// only between items; a finished result waits in the output register, so the next item may enter while it is held.
// ----------------------------------------------------------------------------
module fifo_page_replacement #(
  parameter int FRAMES    = fpr_pkg::FRAMES_DEFAULT,
  parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // command[1:0], page_id[17:2], zero pad
  input  logic [fpr_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // hit[0], fault[1], fault_total[17:2], evict_valid[18], evicted_page[34:19],
  // evicted_dirty[35], refs_cleared[36], resident_count[39:37]
  output logic [fpr_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  logic [fpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import fpr_pkg::*;

  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int OCC_W  = $clog2(FRAMES + 1);

  state_t state, state_next;

  logic [2:0]           frames_in_use;
  logic [15:0]          clear_period;
  logic [SLOT_W-1:0]    oldest;
  logic [OCC_W-1:0]     occupied;
  logic [15:0]          fault_counter;
  logic [15:0]          tick_counter;
  logic [FRAMES-1:0]    referenced;
  logic [FRAMES-1:0]    modified;

  logic [1:0]           cmd;
  logic [PAGE_BITS-1:0] page;
  logic [SLOT_W-1:0]    scan_slot;
  logic [OCC_W-1:0]     scan_count;
  logic                 res_hit;
  logic                 res_fault;
  logic                 res_ev_valid;
  logic                 res_ev_dirty;
  logic [PAGE_BITS-1:0] ev_page;

  logic [PAGE_BITS-1:0] rd_data;
  logic                 ram_we;
  logic                 match;
  logic                 is_write;
  logic                 out_free;
  logic                 evict;
  logic [OCC_W-1:0]     cap;
  logic [SLOT_W-1:0]    scan_slot_inc;
  logic [SLOT_W-1:0]    oldest_inc;
  logic [15:0]          tick_inc;
  logic                 clear_now;
  logic [31:0]          in_page_wide;
  logic [31:0]          ev_page_wide;
  logic [15:0]          ev_page_out;

  fpr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES),
    .ADDR_W(SLOT_W)
  ) u_page_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(scan_slot),
    .wdata(page),
    .raddr(scan_slot),
    .rdata(rd_data)
  );

  assign in_page_wide = 32'(s_tdata[17:2]);
  assign ev_page_wide = 32'(ev_page);
  assign ev_page_out  = res_ev_valid ? ev_page_wide[15:0] : 16'd0;

  always_comb begin
    is_write  = (cmd == CMD_WRITE);
    match     = (rd_data == page);
    out_free  = !m_tvalid || m_tready;
    if (frames_in_use == 3'd0) begin
      cap = OCC_W'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      cap = OCC_W'(FRAMES);
    end else begin
      cap = OCC_W'(frames_in_use);
    end
    evict         = (occupied >= cap) && (occupied != '0);
    scan_slot_inc = (scan_slot == SLOT_W'(FRAMES - 1)) ? '0 : scan_slot + 1'b1;
    oldest_inc    = (oldest == SLOT_W'(FRAMES - 1)) ? '0 : oldest + 1'b1;
    tick_inc      = tick_counter + 16'd1;
    clear_now     = (tick_inc >= clear_period);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if ((s_tdata[1:0] == CMD_READ) || (s_tdata[1:0] == CMD_WRITE)) begin
            state_next = (occupied != '0) ? S_READ : S_MISS;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_READ: state_next = S_CMP;
      S_CMP: begin
        if (match) begin
          state_next = S_DONE;
        end else if (scan_count + 1'b1 == occupied) begin
          state_next = S_MISS;
        end else begin
          state_next = S_READ;
        end
      end
      S_MISS: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = (state == S_IDLE);
    ram_we   = (state == S_MISS);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frames_in_use <= FRAMES_IN_USE_RESET;
      clear_period  <= CLEAR_PERIOD_RESET;
      oldest        <= '0;
      occupied      <= '0;
      fault_counter <= '0;
      tick_counter  <= '0;
      referenced    <= '0;
      modified      <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAMES_IN_USE: frames_in_use <= cfg_data[2:0];
          REG_CLEAR_PERIOD:  clear_period  <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_CMP && match) begin
        referenced[scan_slot] <= 1'b1;
        if (is_write) begin
          modified[scan_slot] <= 1'b1;
        end
      end
      if (state == S_MISS) begin
        if (fault_counter != 16'hFFFF) begin
          fault_counter <= fault_counter + 16'd1;
        end
        referenced[scan_slot] <= 1'b1;
        modified[scan_slot]   <= is_write;
        if (evict) begin
          oldest <= oldest_inc;
        end else begin
          occupied <= occupied + 1'b1;
        end
      end
      if (state == S_DONE && out_free) begin
        m_tvalid     <= 1'b1;
        tick_counter <= clear_now ? 16'd0 : tick_inc;
        if (clear_now) begin
          referenced <= '0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item payload and result fields
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      cmd          <= s_tdata[1:0];
      page         <= in_page_wide[PAGE_BITS-1:0];
      scan_slot    <= oldest;
      scan_count   <= '0;
      res_hit      <= 1'b0;
      res_fault    <= 1'b0;
      res_ev_valid <= 1'b0;
      res_ev_dirty <= 1'b0;
    end
    if (state == S_CMP) begin
      if (scan_count == '0) begin
        ev_page <= rd_data;
      end
      if (match) begin
        res_hit <= 1'b1;
      end else begin
        scan_slot  <= scan_slot_inc;
        scan_count <= scan_count + 1'b1;
      end
    end
    if (state == S_MISS) begin
      res_fault <= 1'b1;
      if (evict) begin
        res_ev_valid <= 1'b1;
        res_ev_dirty <= modified[oldest];
      end
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= {3'(occupied), clear_now, res_ev_dirty, ev_page_out, res_ev_valid,
                  fault_counter, res_fault, res_hit};
    end
  end

  a_occupied_bound: assert property (@(posedge clk) disable iff (rst)
    int'(occupied) <= FRAMES)
    else $error("occupied frames exceed frame count");

  a_hit_or_fault: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("hit and fault in one item");

  a_evict_on_fault: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[1])
    else $error("eviction without fault");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != S_IDLE)
    else $error("accepted item not started");

  a_faults_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> fault_counter >= $past(fault_counter))
    else $error("fault count went down");

endmodule
